// File: src/smsrch_pkg.sv
// Shared types and constants of the sorted matrix search block.
// Used by the front, back and top modules; depends on nothing.
package smsrch_pkg;

   localparam int CFG_W = 5;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // register select, taken from the word address bit of the CSR port
   localparam logic REG_ROWS_IN_USE = 1'b0;
   localparam logic REG_COLS_IN_USE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [3:0]         entry_row;
      logic [3:0]         entry_col;
      logic signed [31:0] data_value;
   } req_type;

   typedef struct packed {
      logic is_search;
      logic found;
   } rsp_type;

   // classified item waiting between front and back
   typedef struct packed {
      logic               is_search;
      logic               wr_ok;
      logic [3:0]         entry_row;
      logic [3:0]         entry_col;
      logic signed [31:0] data_value;
   } item_type;

endpackage

// File: src/smsrch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module smsrch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/smsrch_front.sv
// Front end: accepts request beats, classifies them and queues them.
// Depends on smsrch_pkg; feeds smsrch_back through a two-entry queue.
module smsrch_front
   import smsrch_pkg::*;
#(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_payload,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item_new;

   always_comb begin
      item_new.is_search  = (req_payload.func == FUNC_SEARCH);
      item_new.wr_ok      = (32'(req_payload.entry_row) < MAX_ROWS) &&
                            (32'(req_payload.entry_col) < MAX_COLS);
      item_new.entry_row  = req_payload.entry_row;
      item_new.entry_col  = req_payload.entry_col;
      item_new.data_value = req_payload.data_value;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// File: src/smsrch_back.sv
// Back end: executes queued writes and runs the two binary searches.
// Depends on smsrch_pkg and smsrch_ram; owns the matrix store and result register.
module smsrch_back
   import smsrch_pkg::*;
#(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_COLS   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] rows_in_use,
   input  logic [CFG_W-1:0] cols_in_use,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_ROW_RD  = 5'b00010,
      S_ROW_CMP = 5'b00100,
      S_COL_RD  = 5'b01000,
      S_COL_CMP = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [CFG_W-1:0]               lo_ff, lo_in;
   logic [CFG_W-1:0]               hip1_ff, hip1_in;
   logic [CFG_W-1:0]               mid_ff, mid_in;
   logic [CFG_W-1:0]               pick_ff, pick_in;
   logic [CFG_W-1:0]               ncols_ff, ncols_in;
   logic signed [WORD_WIDTH-1:0]   target_ff, target_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_ff, rsp_in;

   logic                           slot_free;
   logic                           rsp_load;
   logic [CFG_W:0]                 mid_sum;
   logic [CFG_W-1:0]               mid_new;
   logic [CFG_W-1:0]               nrows;
   logic [CFG_W-1:0]               ncols;
   logic signed [63:0]             data_ext;
   logic signed [WORD_WIDTH-1:0]   word;
   logic signed [WORD_WIDTH-1:0]   probe;
   logic                           ram_we;
   logic [ADDR_W-1:0]              ram_waddr;
   logic [ADDR_W-1:0]              ram_raddr;
   logic [WORD_WIDTH-1:0]          ram_rdata;

   smsrch_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (word),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign data_ext  = 64'(q_item.data_value);
   assign word      = data_ext[WORD_WIDTH-1:0];
   assign probe     = $signed(ram_rdata);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hip1_ff} - {{CFG_W{1'b0}}, 1'b1};
   assign mid_new   = mid_sum[CFG_W:1];
   assign ram_waddr = ADDR_W'(32'(q_item.entry_row) * MAX_COLS + 32'(q_item.entry_col));

   always_comb begin
      if (rows_in_use == '0) begin
         nrows = CFG_W'(1);
      end else if (32'(rows_in_use) > MAX_ROWS) begin
         nrows = CFG_W'(MAX_ROWS);
      end else begin
         nrows = rows_in_use;
      end
      if (cols_in_use == '0) begin
         ncols = CFG_W'(1);
      end else if (32'(cols_in_use) > MAX_COLS) begin
         ncols = CFG_W'(MAX_COLS);
      end else begin
         ncols = cols_in_use;
      end
   end

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hip1_in      = hip1_ff;
      mid_in       = mid_ff;
      pick_in      = pick_ff;
      ncols_in     = ncols_ff;
      target_in    = target_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = ADDR_W'(32'(pick_ff) * MAX_COLS + 32'(mid_new));

      case (state_ff)
         S_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               if (q_item.is_search) begin
                  lo_in     = '0;
                  hip1_in   = nrows;
                  pick_in   = '0;
                  ncols_in  = ncols;
                  target_in = word;
                  state_in  = S_ROW_RD;
               end else begin
                  ram_we   = q_item.wr_ok;
                  rsp_load = 1'b1;
                  rsp_in   = '{is_search: 1'b0, found: 1'b0};
               end
            end
         end
         S_ROW_RD: begin
            ram_raddr = ADDR_W'(32'(mid_new) * MAX_COLS);
            if (lo_ff < hip1_ff) begin
               mid_in   = mid_new;
               state_in = S_ROW_CMP;
            end else begin
               lo_in    = '0;
               hip1_in  = ncols_ff;
               state_in = S_COL_RD;
            end
         end
         S_ROW_CMP: begin
            if (probe <= target_ff) begin
               pick_in = mid_ff;
               lo_in   = mid_ff + CFG_W'(1);
            end else begin
               hip1_in = mid_ff;
            end
            state_in = S_ROW_RD;
         end
         S_COL_RD: begin
            if (lo_ff < hip1_ff) begin
               mid_in   = mid_new;
               state_in = S_COL_CMP;
            end else begin
               rsp_load = 1'b1;
               rsp_in   = '{is_search: 1'b1, found: 1'b0};
               state_in = S_IDLE;
            end
         end
         S_COL_CMP: begin
            if (probe == target_ff) begin
               rsp_load = 1'b1;
               rsp_in   = '{is_search: 1'b1, found: 1'b1};
               state_in = S_IDLE;
            end else begin
               if (target_ff < probe) begin
                  hip1_in = mid_ff;
               end else begin
                  lo_in = mid_ff + CFG_W'(1);
               end
               state_in = S_COL_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hip1_ff   <= hip1_in;
      mid_ff    <= mid_in;
      pick_ff   <= pick_in;
      ncols_ff  <= ncols_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROW_CMP || state_ff == S_COL_CMP) |-> (mid_ff < hip1_ff && lo_ff <= mid_ff))
      else $error("probe outside the search window");

   a_found_on_search: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> rsp_ff.is_search)
      else $error("found flag on a write result");

   a_pop_progress: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != S_IDLE || rsp_valid_ff))
      else $error("popped item neither busy nor answered");

endmodule

// File: src/sorted_matrix_search_core.sv
// Top level of the sorted matrix search block: CSR port and front/back wiring.
// Depends on smsrch_pkg, smsrch_front and smsrch_back.
//
// Request beats (req_*) either write one matrix entry or search for a value.
// Every request beat yields exactly one response beat (rsp_*), in order:
// is_search=0, found=0 for a write; is_search=1 and found for a search.
// A search picks the last row whose column 0 entry is at most the target,
// then binary searches that row. Only written entries may be probed.
// rows_in_use (address 0) and cols_in_use (address 4) set the active size;
// write them only while no request is in flight.
// A two-entry queue lets requests be accepted while the back end works.
// A write passes through the queue slot and the response register and uses
// the back end in S_IDLE only, so writes sustain one beat per cycle while
// responses are taken. A search walks S_ROW_RD and S_ROW_CMP per row probe,
// then S_COL_RD and S_COL_CMP per column probe, each probe being one store
// read through the single read port of the matrix store plus one compare.
// Reset empties the queue and the response register and sets both size
// registers to 1; matrix contents are undefined until written.
// A stalled response holds its beat; the back end then stops at the next
// item and the queue fills, after which req_ready drops.
module sorted_matrix_search_core
   import smsrch_pkg::*;
#(
   parameter int MAX_ROWS   = 16,
   parameter int MAX_COLS   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [CFG_W-1:0] rows_in_use_ff, rows_in_use_in;
   logic [CFG_W-1:0] cols_in_use_ff, cols_in_use_in;
   logic             csr_write;
   logic             q_valid;
   logic             q_pop;
   item_type         q_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      rows_in_use_in = rows_in_use_ff;
      cols_in_use_in = cols_in_use_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_ROWS_IN_USE: rows_in_use_in = csr_pwdata[CFG_W-1:0];
            REG_COLS_IN_USE: cols_in_use_in = csr_pwdata[CFG_W-1:0];
            default: begin
               rows_in_use_in = rows_in_use_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_ROWS_IN_USE: csr_prdata = 32'(rows_in_use_ff);
         REG_COLS_IN_USE: csr_prdata = 32'(cols_in_use_ff);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= CFG_W'(1);
         cols_in_use_ff <= CFG_W'(1);
      end else begin
         rows_in_use_ff <= rows_in_use_in;
         cols_in_use_ff <= cols_in_use_in;
      end
   end

   smsrch_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   smsrch_back #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .rows_in_use (rows_in_use_ff),
      .cols_in_use (cols_in_use_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/sorted_matrix_search_core_tb.sv
// Self-checking testbench for sorted_matrix_search_core: writes and searches over sized matrices.
// Compares every response beat with a behavioral predictor kept inside this file.
// Depends on smsrch_pkg and the sorted_matrix_search_core RTL only.
module sorted_matrix_search_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smsrch_pkg::*;

   typedef logic signed [31:0] word_t;

   localparam int     GRID_N      = 16;
   localparam int     ITEM_TARGET = 1650;
   localparam int     CYCLE_LIMIT = 1000000;
   localparam int     SETTLE      = 40;
   localparam word_t  WORD_MIN    = 32'sh8000_0000;
   localparam word_t  WORD_MAX    = 32'sh7FFF_FFFF;
   localparam longint WORD_MIN_L  = -(64'sd1 <<< 31);
   localparam longint WORD_MAX_L  = (64'sd1 <<< 31) - 1;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   word_t       grid_words [GRID_N][GRID_N];
   logic [4:0]  rows_setting = 5'd1;
   logic [4:0]  cols_setting = 5'd1;
   rsp_type     pending_answers [$];

   int sender_gap_max  = 0;
   int reply_stall_max = 0;
   int stall_left      = 0;
   int cycle_count     = 0;
   int mismatch_count  = 0;
   int items_sent      = 0;
   int writes_sent     = 0;
   int searches_sent   = 0;
   int hits_seen       = 0;
   int settings_seen   = 0;

   sorted_matrix_search_core #(
      .MAX_ROWS   (16),
      .MAX_COLS   (16),
      .WORD_WIDTH (32)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats pending", cycle_count,
                  pending_answers.size());
         $display("sorted_matrix_search_core_tb NOT OK");
         $finish;
      end
   end

   function automatic int clamp_size(input logic [4:0] setting);
      if (setting == 0)
         return 1;
      return (setting > GRID_N) ? GRID_N : int'(setting);
   endfunction

   function automatic logic search_hit(input word_t target);
      int   lo;
      int   hi;
      int   mid;
      int   pick;
      logic hit;
      lo   = 0;
      hi   = clamp_size(rows_setting) - 1;
      pick = 0;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (grid_words[mid][0] <= target) begin
            pick = mid;
            lo   = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      lo  = 0;
      hi  = clamp_size(cols_setting) - 1;
      hit = 1'b0;
      while (lo <= hi && !hit) begin
         mid = lo + (hi - lo) / 2;
         if (grid_words[pick][mid] == target)
            hit = 1'b1;
         else if (target < grid_words[pick][mid])
            hi = mid - 1;
         else
            lo = mid + 1;
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_ready && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("response beat with nothing pending: is_search %0b found %0b",
                   rsp_payload.is_search, rsp_payload.found);
            mismatch_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_payload.is_search !== want.is_search) begin
               $error("is_search: expected %0b, got %0b", want.is_search,
                      rsp_payload.is_search);
               mismatch_count++;
            end
            if (rsp_payload.found !== want.found) begin
               $error("found: expected %0b, got %0b", want.found, rsp_payload.found);
               mismatch_count++;
            end
            if (want.is_search && want.found)
               hits_seen++;
         end
         stall_left = $urandom_range(0, reply_stall_max);
         if (stall_left != 0)
            rsp_ready <= 1'b0;
      end else if (!rsp_ready) begin
         if (stall_left <= 1)
            rsp_ready <= 1'b1;
         if (stall_left != 0)
            stall_left--;
      end
   end

   task automatic send_item(input req_type beat);
      int      gap;
      rsp_type want;
      gap = $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (!req_ready);
      want.is_search = (beat.func == FUNC_SEARCH);
      want.found     = 1'b0;
      if (beat.func == FUNC_SEARCH) begin
         want.found = search_hit(beat.data_value);
         searches_sent++;
      end else begin
         grid_words[beat.entry_row][beat.entry_col] = beat.data_value;
         writes_sent++;
      end
      pending_answers.push_back(want);
      items_sent++;
   endtask

   task automatic do_write(input int row, input int col, input word_t value);
      req_type beat;
      beat.func       = FUNC_WRITE;
      beat.entry_row  = 4'(row);
      beat.entry_col  = 4'(col);
      beat.data_value = value;
      send_item(beat);
   endtask

   task automatic do_search(input word_t target);
      req_type beat;
      beat.func       = FUNC_SEARCH;
      beat.entry_row  = 4'($urandom);
      beat.entry_col  = 4'($urandom);
      beat.data_value = target;
      send_item(beat);
   endtask

   // hold off new beats until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [4:0] size);
      logic [31:0] value;
      value = {27'($urandom), size};
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_sel == REG_ROWS_IN_USE)
         rows_setting = value[4:0];
      else
         cols_setting = value[4:0];
      @(posedge clock);
   endtask

   function automatic int idle_choice();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 16;
      endcase
   endfunction

   function automatic word_t pick_target(input int nr, input int nc);
      int row;
      int col;
      int sel;
      row = $urandom_range(0, nr - 1);
      col = $urandom_range(0, nc - 1);
      sel = $urandom_range(0, 99);
      if (sel < 40)
         return grid_words[row][col];
      if (sel < 50)
         return grid_words[row][col] + 1;
      if (sel < 60)
         return grid_words[row][col] - 1;
      if (sel < 80)
         return word_t'($urandom);
      if (sel < 88)
         return grid_words[row][0];
      if (sel < 94)
         return WORD_MIN;
      return WORD_MAX;
   endfunction

   // fill the active region in ascending order, duplicates and saturation allowed
   task automatic refresh_sorted(input int nr, input int nc);
      longint level;
      int     step_cap;
      case ($urandom_range(0, 3))
         0:       step_cap = 1;
         1:       step_cap = 1000;
         2:       step_cap = 1 << 20;
         default: step_cap = 1 << 25;
      endcase
      if ($urandom_range(0, 3) == 0)
         level = WORD_MIN_L;
      else
         level = WORD_MIN_L + longint'($urandom_range(0, 32'hC000_0000));
      for (int row = 0; row < nr; row++) begin
         for (int col = 0; col < nc; col++) begin
            do_write(row, col, word_t'(level));
            level += longint'($urandom_range(0, step_cap));
            if (level > WORD_MAX_L)
               level = WORD_MAX_L;
         end
      end
   endtask

   task automatic run_phase(input int rows_val, input int cols_val, input bit refresh,
                            input int n_items);
      int    nr;
      int    nc;
      int    pick;
      int    row;
      int    col;
      word_t value;
      drain();
      csr_write(REG_ROWS_IN_USE, 5'(rows_val));
      csr_write(REG_COLS_IN_USE, 5'(cols_val));
      settings_seen++;
      nr = clamp_size(rows_setting);
      nc = clamp_size(cols_setting);
      if (refresh) begin
         sender_gap_max  = 0;
         reply_stall_max = 0;
         refresh_sorted(nr, nc);
      end
      sender_gap_max  = idle_choice();
      reply_stall_max = idle_choice();
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            drain();
         end else if (pick < 15) begin
            row   = $urandom_range(0, GRID_N - 1);
            col   = $urandom_range(0, GRID_N - 1);
            value = $urandom_range(0, 1) ? word_t'($urandom) : grid_words[row][col];
            do_write(row, col, value);
         end else begin
            do_search(pick_target(nr, nc));
         end
      end
   endtask

   task automatic test_directed();
      sender_gap_max  = 2;
      reply_stall_max = 2;
      do_write(0, 0, WORD_MIN);
      do_search(WORD_MIN);
      do_search(WORD_MAX);
      do_write(15, 15, WORD_MAX);
      do_write(0, 0, WORD_MAX);
      do_search(WORD_MAX);
      do_search(WORD_MIN);
      do_write(0, 0, 32'sd0);
      do_search(32'sd0);
      do_search(-32'sd1);
      do_search(32'sd1);
      drain();
      csr_write(REG_ROWS_IN_USE, 5'd0);
      csr_write(REG_COLS_IN_USE, 5'd0);
      settings_seen++;
      do_search(32'sd0);
      do_search(WORD_MIN);
   endtask

   task automatic test_full_matrix();
      run_phase(16, 16, 1'b1, 120);
   endtask

   task automatic test_size_extremes();
      run_phase(31, 31, 1'b0, 100);
      run_phase(1, 16, 1'b1, 100);
      run_phase(16, 1, 1'b1, 100);
      run_phase(0, 0, 1'b1, 60);
      run_phase(17, 5, 1'b1, 100);
   endtask

   task automatic test_random_sizes();
      int rows_val;
      int cols_val;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            rows_val = $urandom_range(0, 31);
            cols_val = $urandom_range(0, 31);
         end else begin
            rows_val = $urandom_range(1, 6);
            cols_val = $urandom_range(1, 6);
         end
         run_phase(rows_val, cols_val, 1'b1, $urandom_range(40, 90));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_matrix();
      test_size_extremes();
      test_random_sizes();
      drain();
      repeat (SETTLE) @(posedge clock);
      $display("ran %0d beats: %0d entry writes, %0d lookups with %0d hits",
               items_sent, writes_sent, searches_sent, hits_seen);
      $display("swept %0d matrix size settings, including clamped values",
               settings_seen);
      if (mismatch_count == 0)
         $display("sorted_matrix_search_core_tb OK");
      else
         $display("sorted_matrix_search_core_tb NOT OK");
      $finish;
   end

endmodule

// File: sim.f
src/smsrch_pkg.sv
src/smsrch_ram.sv
src/smsrch_front.sv
src/smsrch_back.sv
src/sorted_matrix_search_core.sv
tb/sorted_matrix_search_core_tb.sv
